@@ design/rgb_histogram_bar_chart_defines.svh @@
`ifndef RGB_HISTOGRAM_BAR_CHART_DEFINES_SVH
`define RGB_HISTOGRAM_BAR_CHART_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RHBC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhbc: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define RHBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rhbc: next-cycle check failed");

`endif

@@ design/rhbc_pkg.sv @@
package rhbc_pkg;

   localparam int DEFAULT_BINS       = 256;
   localparam int DEFAULT_COUNT_BITS = 32;
   localparam int VALUE_BITS         = 8;
   localparam int OUT_BITS           = 32;
   // bars are scaled to 256 rows
   localparam int CHART_SHIFT        = 8;
   localparam int CHANNELS           = 3;
   localparam int CH_RED             = 0;
   localparam int CH_GREEN           = 1;
   localparam int CH_BLUE            = 2;
   localparam int QUEUE_DEPTH        = 2;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_ACCUM = 2'd1,
      MODE_READ  = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR
   } back_state_type;

   typedef struct packed {
      logic [1:0]            mode;
      logic [VALUE_BITS-1:0] red;
      logic [VALUE_BITS-1:0] green;
      logic [VALUE_BITS-1:0] blue;
      logic [VALUE_BITS-1:0] bin_index;
      logic [VALUE_BITS-1:0] chart_row;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] red_count;
      logic [OUT_BITS-1:0] green_count;
      logic [OUT_BITS-1:0] blue_count;
      logic                red_lit;
      logic                green_lit;
      logic                blue_lit;
      logic [OUT_BITS-1:0] peak_count;
   } rsp_type;

   // Classified command: one bin index and one in-range flag per channel
   typedef struct packed {
      mode_type                             op;
      logic [CHANNELS-1:0]                  hit;
      logic [CHANNELS-1:0][VALUE_BITS-1:0]  idx;
      logic [VALUE_BITS-1:0]                row;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic q_full;
      logic init_busy;
   } front_status_type;

endpackage

@@ design/rhbc_front.sv @@
module rhbc_front #(
   parameter int BINS = rhbc_pkg::DEFAULT_BINS
) (
   input  logic                       start,
   output logic                       busy,
   input  rhbc_pkg::req_type          req_data,
   input  rhbc_pkg::front_status_type status,
   output logic                       push,
   output rhbc_pkg::cmd_type          push_cmd
);
   import rhbc_pkg::*;

   localparam int ADDR_W = $clog2(BINS);
   localparam int CMP_W  = ((ADDR_W > VALUE_BITS) ? ADDR_W : VALUE_BITS) + 1;
   localparam logic [CMP_W-1:0] BIN_LIMIT = CMP_W'(BINS);

   mode_type op;

   function automatic logic in_range(input logic [VALUE_BITS-1:0] v);
      return CMP_W'(v) < BIN_LIMIT;
   endfunction

   assign busy = status.q_full | status.init_busy;
   assign push = start & ~busy;
   assign op   = mode_type'(req_data.mode);

   always_comb begin
      push_cmd     = '0;
      push_cmd.op  = op;
      push_cmd.row = req_data.chart_row;
      unique case (op)
         MODE_ACCUM: begin
            push_cmd.idx[CH_RED]   = req_data.red;
            push_cmd.idx[CH_GREEN] = req_data.green;
            push_cmd.idx[CH_BLUE]  = req_data.blue;
         end
         default: begin
            push_cmd.idx[CH_RED]   = req_data.bin_index;
            push_cmd.idx[CH_GREEN] = req_data.bin_index;
            push_cmd.idx[CH_BLUE]  = req_data.bin_index;
         end
      endcase
      for (int ch = 0; ch < CHANNELS; ch++) begin
         push_cmd.hit[ch] = in_range(push_cmd.idx[ch]);
      end
   end

endmodule

@@ design/rhbc_queue.sv @@
`include "rgb_histogram_bar_chart_defines.svh"

module rhbc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rhbc_pkg::cmd_type        push_cmd,
   input  logic                     pop,
   output rhbc_pkg::queue_head_type head,
   output logic                     full
);
   import rhbc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign full       = (count_ff == CNT_FULL);

   `RHBC_ASSERT_SAME(a_no_overrun, clock, reset, push, !full)
   `RHBC_ASSERT_SAME(a_no_underrun, clock, reset, pop, head.valid)
   `RHBC_ASSERT_NEXT(a_head_kept, clock, reset, head.valid && !pop, head.valid)

endmodule

@@ design/rhbc_back.sv @@
`include "rgb_histogram_bar_chart_defines.svh"

module rhbc_back #(
   parameter int BINS       = rhbc_pkg::DEFAULT_BINS,
   parameter int COUNT_BITS = rhbc_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rhbc_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     init_busy,
   output logic                     rsp_valid,
   output rhbc_pkg::rsp_type        rsp_data
);
   import rhbc_pkg::*;

   localparam int ADDR_W = $clog2(BINS);
   localparam int IDX_W  = (ADDR_W > VALUE_BITS) ? ADDR_W : VALUE_BITS;
   localparam int PROD_W = COUNT_BITS + VALUE_BITS + 1;
   localparam int WIDE_W = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
   localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(BINS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   back_state_type          state_ff, state_in;
   logic [ADDR_W-1:0]       sweep_ff, sweep_in;
   logic [COUNT_BITS-1:0]   peak_ff, peak_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [CHANNELS-1:0][ADDR_W-1:0]     rd_addr;
   logic [CHANNELS-1:0][ADDR_W-1:0]     exec_addr;
   logic [CHANNELS-1:0][ADDR_W-1:0]     wr_addr;
   logic [CHANNELS-1:0]                 wr_en;
   logic [CHANNELS-1:0][COUNT_BITS-1:0] wr_data;
   logic [CHANNELS-1:0][COUNT_BITS-1:0] rdata;
   logic [CHANNELS-1:0][COUNT_BITS-1:0] bumped;
   logic [CHANNELS-1:0][PROD_W-1:0]     scaled;
   logic [CHANNELS-1:0]                 lit;
   logic [COUNT_BITS-1:0]               peak_acc;
   logic [VALUE_BITS:0]                 row_plus;
   logic                                sweep_last;

   function automatic logic [ADDR_W-1:0] to_addr(input logic [VALUE_BITS-1:0] v);
      logic [IDX_W-1:0] ext;
      ext = IDX_W'(v);
      return ext[ADDR_W-1:0];
   endfunction

   function automatic logic [OUT_BITS-1:0] fit_out(input logic [COUNT_BITS-1:0] c);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(c);
      return wide[OUT_BITS-1:0];
   endfunction

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_bank
      logic [COUNT_BITS-1:0] mem [BINS];
      logic [COUNT_BITS-1:0] rdata_ff;

      always_ff @(posedge clock) begin
         if (wr_en[ch]) begin
            mem[wr_addr[ch]] <= wr_data[ch];
         end
         rdata_ff <= mem[rd_addr[ch]];
      end

      assign rdata[ch]     = rdata_ff;
      assign rd_addr[ch]   = to_addr(head.cmd.idx[ch]);
      assign exec_addr[ch] = to_addr(cmd_ff.idx[ch]);
      // hold a saturated count
      assign bumped[ch]    = (rdata_ff == COUNT_MAX) ? rdata_ff : rdata_ff + COUNT_BITS'(1);
      // floor(count*256/peak) > row  <=>  count*256 >= (row+1)*peak
      assign scaled[ch]    = PROD_W'(rdata_ff) << CHART_SHIFT;
      assign lit[ch]       = cmd_ff.hit[ch] && (peak_ff != '0) && (scaled[ch] >= prod_ff);
   end

   assign sweep_last = (sweep_ff == LAST_ADDR);
   assign row_plus   = (VALUE_BITS + 1)'(head.cmd.row) + (VALUE_BITS + 1)'(1);

   always_comb begin
      peak_acc = peak_ff;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (cmd_ff.hit[ch] && (bumped[ch] > peak_acc)) begin
            peak_acc = bumped[ch];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (head.valid) begin
               state_in = (head.cmd.op == MODE_CLEAR) ? ST_CLEAR : ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop          = 1'b0;
      init_busy    = (state_ff == ST_INIT);
      sweep_in     = sweep_ff;
      peak_in      = peak_ff;
      cmd_in       = cmd_ff;
      prod_in      = prod_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      wr_en        = '0;
      wr_addr      = exec_addr;
      wr_data      = bumped;
      unique case (state_ff) inside
         ST_INIT, ST_CLEAR: begin
            wr_en    = '1;
            wr_data  = '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
               wr_addr[ch] = sweep_ff;
            end
            sweep_in = sweep_last ? '0 : sweep_ff + ADDR_W'(1);
            if (state_ff == ST_CLEAR && sweep_last) begin
               rsp_valid_in = 1'b1;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               cmd_in  = head.cmd;
               prod_in = PROD_W'(peak_ff) * PROD_W'(row_plus);
               if (head.cmd.op == MODE_CLEAR) begin
                  peak_in = '0;
               end
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            unique case (cmd_ff.op)
               MODE_ACCUM: begin
                  wr_en   = cmd_ff.hit;
                  peak_in = peak_acc;
               end
               MODE_READ: begin
                  rsp_data_in.red_count   = cmd_ff.hit[CH_RED]   ? fit_out(rdata[CH_RED])   : '0;
                  rsp_data_in.green_count = cmd_ff.hit[CH_GREEN] ? fit_out(rdata[CH_GREEN]) : '0;
                  rsp_data_in.blue_count  = cmd_ff.hit[CH_BLUE]  ? fit_out(rdata[CH_BLUE])  : '0;
               end
               MODE_QUERY: begin
                  rsp_data_in.red_lit   = lit[CH_RED];
                  rsp_data_in.green_lit = lit[CH_GREEN];
                  rsp_data_in.blue_lit  = lit[CH_BLUE];
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         default: begin
            wr_en = '0;
         end
      endcase
      rsp_data_in.peak_count = fit_out(peak_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RHBC_ASSERT_SAME(a_init_quiet, clock, reset, state_ff == ST_INIT, !rsp_valid_ff)
   `RHBC_ASSERT_NEXT(a_peak_grows, clock, reset, state_ff == ST_EXEC, peak_ff >= $past(peak_ff))
   `RHBC_ASSERT_NEXT(a_clear_beat, clock, reset, state_ff == ST_CLEAR && sweep_last,
      rsp_valid_ff && rsp_data_ff.peak_count == '0)

endmodule

@@ design/rgb_histogram_bar_chart.sv @@
// Accumulate, read bin and bar query each pass from the queue through the back end's idle
// state (pop and bin memory read) and execute state (update or compare); the result is
// registered onto rsp_data; the back end takes no new command until it is back in idle,
// and a two-entry queue absorbs short bursts. Clear writes one zero per bin into the three
// bin memories. Reset: the same sweep runs with busy high and no result strobed.
// Each result stands on rsp_data for exactly one cycle, marked by rsp_valid.
module rgb_histogram_bar_chart #(
   parameter int BINS       = rhbc_pkg::DEFAULT_BINS,
   parameter int COUNT_BITS = rhbc_pkg::DEFAULT_COUNT_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rhbc_pkg::req_type req_data,
   output logic              rsp_valid,
   output rhbc_pkg::rsp_type rsp_data
);
   import rhbc_pkg::*;

   front_status_type status;
   queue_head_type   head;
   cmd_type          push_cmd;
   logic             push;
   logic             pop;
   logic             q_full;
   logic             init_busy;

   assign status.q_full    = q_full;
   assign status.init_busy = init_busy;

   rhbc_front #(
      .BINS(BINS)
   ) u_front (
      .start   (start),
      .busy    (busy),
      .req_data(req_data),
      .status  (status),
      .push    (push),
      .push_cmd(push_cmd)
   );

   rhbc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head    (head),
      .full    (q_full)
   );

   rhbc_back #(
      .BINS      (BINS),
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .init_busy(init_busy),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule
